// ----- rtl/core/u8u16_pkg.sv -----
// Shared types and constants for the UTF-8 to counted UTF-16 transcoder.
package u8u16_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] unit_t;
    typedef logic [20:0] cp_t;

    // Unit limit handling
    localparam byte_t LIMIT_RESET = 8'd254;
    localparam byte_t LIMIT_CAP   = 8'd254;

    // Code unit constants
    localparam unit_t REPL_UNIT    = 16'h003F;
    localparam unit_t TERM_UNIT    = 16'h0000;
    localparam unit_t HI_SURR_BASE = 16'hD800;
    localparam unit_t LO_SURR_BASE = 16'hDC00;
    localparam unit_t SURR_LAST    = 16'hDFFF;
    localparam unit_t MIN_CP3      = 16'h0800;
    localparam logic [10:0] MIN_CP2 = 11'h080;
    localparam byte_t CTRL_LIMIT   = 8'h20;

    // Code point range for four-byte forms
    localparam cp_t SUPP_BASE = 21'h010000;
    localparam cp_t CP_MAX    = 21'h10FFFF;

    // Expected sequence length codes
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_2    = 3'd2;
    localparam logic [2:0] SEQ_3    = 3'd3;
    localparam logic [2:0] SEQ_4    = 3'd4;

endpackage

// ----- rtl/core/utf8_to_counted_utf16_core.sv -----
// UTF-8 to counted UTF-16 transcoder: top level.
//
// Takes one UTF-8 byte per item and returns UTF-16 code units; a zero byte
// closes the string with a terminator item carrying units+1 (or a single
// empty-string item with unit_valid low and count 0). Each accepted byte sits
// in an input register, is decoded combinationally against the pending
// sequence state, and its zero to four results are loaded together into a
// four-entry result register that drains one item per cycle while m_ready
// is high. Input rate is one byte per cycle while each byte yields at most
// one result and m_ready is high; a byte that yields more results holds the
// result register until they drain, so the next byte waits for them.
// The unit limit is written through cfg_wr_en/cfg_wr_data and resets to 254;
// values above 254 act as 254.
module utf8_to_counted_utf16_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  u8u16_pkg::byte_t  cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  u8u16_pkg::byte_t  s_text_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output u8u16_pkg::unit_t  m_code_unit,
    output logic              m_unit_valid,
    output logic              m_end_of_string,
    output u8u16_pkg::byte_t  m_char_count,
    output logic              m_last_of_run
);
    import u8u16_pkg::*;

    // Configuration
    byte_t       limit_reg;
    logic [8:0]  lim9;

    // Input register
    logic        in_valid_reg;
    byte_t       in_byte_reg;

    // Decoder state
    byte_t       pend_reg [3];
    logic [1:0]  pend_cnt_reg, pend_cnt_next;
    logic [2:0]  seq_len_reg, seq_len_next;
    byte_t       units_reg, units_next;
    logic        stopped_reg, stopped_next;
    logic        pend_wr_en;
    logic [1:0]  pend_wr_idx;

    // Result register
    unit_t       unit_reg [4];
    logic [2:0]  buf_cnt_reg;
    logic        end_reg;
    logic        end_valid_reg;
    byte_t       end_count_reg;

    // Decode signals
    byte_t       b;
    logic        is_zero, is_cont, do_flush, at_end, empty_str;
    logic [1:0]  flush_n, tail_n;
    logic [8:0]  u_f, u_acc;
    logic        st_f;
    unit_t       tail0, tail1;
    logic        tail_end, tail_end_valid;
    byte_t       tail_end_count;
    logic [2:0]  n_total;
    unit_t       unit_load [4];
    cp_t         cp4, cp_off;
    logic [10:0] cp2;
    unit_t       cp3;
    logic        can_load, adv, pop;

    assign lim9 = {1'b0, (limit_reg > LIMIT_CAP) ? LIMIT_CAP : limit_reg};

    // Handshake: the input register moves when the result register frees up
    assign can_load = (buf_cnt_reg == 3'd0) || ((buf_cnt_reg == 3'd1) && m_ready);
    assign adv      = in_valid_reg && can_load;
    assign pop      = (buf_cnt_reg != 3'd0) && m_ready;
    assign s_ready  = !in_valid_reg || can_load;

    assign b       = in_byte_reg;
    assign is_zero = (b == 8'd0);
    assign is_cont = (b[7:6] == 2'b10);
    assign cp4     = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0], b[5:0]};
    assign cp_off  = cp4 - SUPP_BASE;
    assign cp2     = {pend_reg[0][4:0], b[5:0]};
    assign cp3     = {pend_reg[0][3:0], pend_reg[1][5:0], b[5:0]};

    // Broken sequence: lead and each held continuation byte become '?', up to the limit
    always_comb begin
        do_flush = (pend_cnt_reg != 2'd0) && !stopped_reg && (is_zero || !is_cont);
        flush_n  = 2'd0;
        u_f      = {1'b0, units_reg};
        st_f     = stopped_reg;
        if (do_flush) begin
            flush_n = 2'd1;
            u_f     = {1'b0, units_reg} + 9'd1;
            st_f    = 1'b0;
            if (pend_cnt_reg >= 2'd2) begin
                if (u_f >= lim9) begin
                    st_f = 1'b1;
                end else begin
                    flush_n = 2'd2;
                    u_f     = u_f + 9'd1;
                end
            end
            if ((pend_cnt_reg == 2'd3) && !st_f) begin
                if (u_f >= lim9) begin
                    st_f = 1'b1;
                end else begin
                    flush_n = 2'd3;
                    u_f     = u_f + 9'd1;
                end
            end
        end
    end

    // Decode the current byte after any flush
    always_comb begin
        tail_n         = 2'd0;
        tail0          = REPL_UNIT;
        tail1          = REPL_UNIT;
        tail_end       = 1'b0;
        tail_end_valid = 1'b0;
        tail_end_count = 8'd0;
        empty_str      = (units_reg == 8'd0) && (pend_cnt_reg == 2'd0) && !stopped_reg;
        u_acc          = u_f;
        stopped_next   = st_f;
        pend_cnt_next  = do_flush ? 2'd0 : pend_cnt_reg;
        seq_len_next   = do_flush ? SEQ_NONE : seq_len_reg;
        pend_wr_en     = 1'b0;
        pend_wr_idx    = 2'd0;
        if (is_zero) begin
            // Close the string and clear all string state
            tail_n         = 2'd1;
            tail0          = TERM_UNIT;
            tail_end       = 1'b1;
            tail_end_valid = !empty_str;
            tail_end_count = empty_str ? 8'd0 : (u_f[7:0] + 8'd1);
            u_acc          = 9'd0;
            stopped_next   = 1'b0;
            pend_cnt_next  = 2'd0;
            seq_len_next   = SEQ_NONE;
        end else if (st_f) begin
            // Drop bytes until the string ends
        end else if (!do_flush && (pend_cnt_reg != 2'd0)) begin
            if (({1'b0, pend_cnt_reg} + 3'd1) >= seq_len_reg) begin
                pend_cnt_next = 2'd0;
                seq_len_next  = SEQ_NONE;
                case (seq_len_reg)
                    SEQ_4: begin
                        if ((cp4 < SUPP_BASE) || (cp4 > CP_MAX)) begin
                            tail_n = 2'd1;
                            u_acc  = u_f + 9'd1;
                        end else if ((u_f + 9'd2) > lim9) begin
                            stopped_next = 1'b1;
                        end else begin
                            tail_n = 2'd2;
                            tail0  = HI_SURR_BASE + {6'd0, cp_off[19:10]};
                            tail1  = LO_SURR_BASE + {6'd0, cp_off[9:0]};
                            u_acc  = u_f + 9'd2;
                        end
                    end
                    SEQ_2: begin
                        tail_n = 2'd1;
                        tail0  = (cp2 < MIN_CP2) ? REPL_UNIT : {5'd0, cp2};
                        u_acc  = u_f + 9'd1;
                    end
                    default: begin
                        tail_n = 2'd1;
                        tail0  = ((cp3 < MIN_CP3) ||
                                  ((cp3 >= HI_SURR_BASE) && (cp3 <= SURR_LAST)))
                                 ? REPL_UNIT : cp3;
                        u_acc  = u_f + 9'd1;
                    end
                endcase
            end else begin
                // Hold the continuation byte
                pend_wr_en    = 1'b1;
                pend_wr_idx   = pend_cnt_reg;
                pend_cnt_next = pend_cnt_reg + 2'd1;
            end
        end else begin
            // Start a new character
            if (u_f >= lim9) begin
                stopped_next = 1'b1;
            end else if (!b[7]) begin
                tail_n = 2'd1;
                tail0  = (b < CTRL_LIMIT) ? REPL_UNIT : {8'd0, b};
                u_acc  = u_f + 9'd1;
            end else if (b[7:5] == 3'b110) begin
                pend_wr_en    = 1'b1;
                pend_cnt_next = 2'd1;
                seq_len_next  = SEQ_2;
            end else if (b[7:4] == 4'b1110) begin
                pend_wr_en    = 1'b1;
                pend_cnt_next = 2'd1;
                seq_len_next  = SEQ_3;
            end else if (b[7:3] == 5'b11110) begin
                pend_wr_en    = 1'b1;
                pend_cnt_next = 2'd1;
                seq_len_next  = SEQ_4;
            end else begin
                tail_n = 2'd1;
                u_acc  = u_f + 9'd1;
            end
        end
        units_next = u_acc[7:0];
    end

    // Line up flush replacements ahead of the byte's own units
    always_comb begin
        n_total = {1'b0, flush_n} + {1'b0, tail_n};
        for (int i = 0; i < 4; i++) begin
            if (2'(i) < flush_n) begin
                unit_load[i] = REPL_UNIT;
            end else if (2'(i) == flush_n) begin
                unit_load[i] = tail0;
            end else begin
                unit_load[i] = tail1;
            end
        end
    end

    // Configuration, input register and decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= LIMIT_RESET;
            in_valid_reg <= 1'b0;
            pend_cnt_reg <= 2'd0;
            seq_len_reg  <= SEQ_NONE;
            units_reg    <= 8'd0;
            stopped_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv) begin
                pend_cnt_reg <= pend_cnt_next;
                seq_len_reg  <= seq_len_next;
                units_reg    <= units_next;
                stopped_reg  <= stopped_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
        end
        if (adv && pend_wr_en) begin
            pend_reg[pend_wr_idx] <= b;
        end
    end

    // Result register: load a run, then shift one item out per handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_cnt_reg <= 3'd0;
        end else if (adv) begin
            buf_cnt_reg <= n_total;
        end else if (pop) begin
            buf_cnt_reg <= buf_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                unit_reg[i] <= unit_load[i];
            end
            end_reg       <= tail_end;
            end_valid_reg <= tail_end_valid;
            end_count_reg <= tail_end_count;
        end else if (pop) begin
            for (int i = 0; i < 3; i++) begin
                unit_reg[i] <= unit_reg[i + 1];
            end
        end
    end

    // Drive the result channel
    assign at_end          = (buf_cnt_reg == 3'd1) && end_reg;
    assign m_valid         = (buf_cnt_reg != 3'd0);
    assign m_code_unit     = unit_reg[0];
    assign m_last_of_run   = (buf_cnt_reg == 3'd1);
    assign m_end_of_string = at_end;
    assign m_unit_valid    = at_end ? end_valid_reg : 1'b1;
    assign m_char_count    = at_end ? end_count_reg : 8'd0;

endmodule

// ----- rtl/core/u8u16_chk.sv -----
// Port-level checker for the transcoder and its bind to the top level.
module u8u16_chk (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input u8u16_pkg::unit_t  m_code_unit,
    input logic              m_unit_valid,
    input logic              m_end_of_string,
    input u8u16_pkg::byte_t  m_char_count,
    input logic              m_last_of_run
);
    import u8u16_pkg::*;

    // The item that closes a string is always the last of its run
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_string |-> m_last_of_run)
        else $error("end item not marked last of run");

    // Only the empty-string end item drops unit_valid, with zero unit and count
    a_empty_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_unit_valid |->
            m_end_of_string && (m_char_count == 8'd0) && (m_code_unit == TERM_UNIT))
        else $error("bad empty-string item");

    // A terminator carries a zero unit and a nonzero count
    a_terminator: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_string && m_unit_valid |->
            (m_code_unit == TERM_UNIT) && (m_char_count != 8'd0))
        else $error("bad terminator item");

    // Ordinary units carry no count
    a_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_end_of_string |-> (m_char_count == 8'd0))
        else $error("count on a non-end item");

    // A stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_unit))
        else $error("stalled item changed");

endmodule

bind utf8_to_counted_utf16_core u8u16_chk u_chk (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_code_unit     (m_code_unit),
    .m_unit_valid    (m_unit_valid),
    .m_end_of_string (m_end_of_string),
    .m_char_count    (m_char_count),
    .m_last_of_run   (m_last_of_run)
);
